### src/mmio_range_table_lookup_macros.svh
// Assertion helpers shared by the range table RTL.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef MMIO_RANGE_TABLE_LOOKUP_MACROS_SVH
`define MMIO_RANGE_TABLE_LOOKUP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MRTL_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MRTL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/mrtl_pkg.sv
package mrtl_pkg;

   localparam int ADDR_W = 32;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   // qualification bit positions
   localparam int Q_READ_BIT  = 0;
   localparam int Q_WRITE_BIT = 1;
   localparam int Q_FETCH_BIT = 2;

   // result status codes
   localparam logic [2:0] ST_HIT        = 3'd0;
   localparam logic [2:0] ST_WALK_FAULT = 3'd1;
   localparam logic [2:0] ST_FETCH      = 3'd2;
   localparam logic [2:0] ST_MISS       = 3'd3;
   localparam logic [2:0] ST_NO_HANDLER = 3'd4;
   localparam logic [2:0] ST_INSERTED   = 3'd5;
   localparam logic [2:0] ST_FULL       = 3'd6;

   // one stored range
   typedef struct packed {
      logic [ADDR_W-1:0] start_addr;
      logic [ADDR_W-1:0] end_addr;
      logic              rd_ok;
      logic              wr_ok;
   } entry_type;

   // outcome of the shared compare unit
   typedef struct packed {
      logic              below_start;
      logic              within_end;
      logic [ADDR_W-1:0] offset;
   } cmp_type;

endpackage

### src/mrtl_cmp.sv
module mrtl_cmp (
   input  logic [mrtl_pkg::ADDR_W-1:0] key,
   input  logic [mrtl_pkg::ADDR_W-1:0] lo,
   input  logic [mrtl_pkg::ADDR_W-1:0] hi,
   output mrtl_pkg::cmp_type           result
);

   logic [mrtl_pkg::ADDR_W:0] key_minus_lo;
   logic [mrtl_pkg::ADDR_W:0] hi_minus_key;

   // borrow out of key - lo means key < lo; the difference is the offset
   assign key_minus_lo = {1'b0, key} - {1'b0, lo};
   // no borrow out of hi - key means key <= hi
   assign hi_minus_key = {1'b0, hi} - {1'b0, key};

   assign result.below_start = key_minus_lo[mrtl_pkg::ADDR_W];
   assign result.within_end  = ~hi_minus_key[mrtl_pkg::ADDR_W];
   assign result.offset      = key_minus_lo[mrtl_pkg::ADDR_W-1:0];

endmodule

### src/mmio_range_table_lookup.sv
// Sorted address range table with access lookup.
// Input words arrive on req_valid/req_ready: req_type 0 inserts
// [req_range_start, req_range_end] with its read/write handler marks,
// req_type 1 classifies req_qualification and looks up req_access_addr.
// Every input word yields exactly one result word on rsp_valid/rsp_ready.
// The block takes one word at a time: req_ready is high only while idle.
// One compare unit walks the table one entry per cycle, reading a
// table memory with one write port and one registered read port.
// Walk fault, fetch, full and a lookup on an empty table finish in the start
// state; a lookup examines entries in order, up to the fill count; an insert
// scans for its slot, moves any entries above it up one place, then writes
// the new range. The next word is taken only after the result is loaded and
// the sequencer is back in idle.
// Reset empties the table at once (fill count to zero); no clearing pass.
// A stalled rsp_ready holds the result word in the output register and the
// sequencer waits on the next result until the register frees.
`include "mmio_range_table_lookup_macros.svh"

module mmio_range_table_lookup #(
   parameter int MAX_RANGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [31:0] req_access_addr,
   input  logic [2:0]  req_qualification,
   input  logic [31:0] req_range_start,
   input  logic [31:0] req_range_end,
   input  logic        req_read_allowed,
   input  logic        req_write_allowed,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_entry_index,
   output logic [31:0] rsp_range_offset,
   output logic        rsp_is_read
);

   localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
   localparam int CNT_W = $clog2(MAX_RANGES + 1);

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_START = 6'b000010,
      S_SCAN  = 6'b000100,
      S_FIND  = 6'b001000,
      S_SHIFT = 6'b010000,
      S_PLACE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [CNT_W-1:0] idx_inc, idx_dec, idx_dec2, count_dec;

   // captured request word
   logic        type_ff;
   logic [31:0] key_ff;
   logic [31:0] end_ff;
   logic        rflag_ff;
   logic        wflag_ff;
   logic [2:0]  qual_ff;

   // table memory
   mrtl_pkg::entry_type table_ff [MAX_RANGES];
   mrtl_pkg::entry_type rd_data_ff;
   mrtl_pkg::entry_type mem_wdata;
   logic [IDX_W-1:0]    rd_addr;
   logic [IDX_W-1:0]    mem_waddr;
   logic                mem_we;

   mrtl_pkg::cmp_type cmp;

   // result staging and output register
   logic             finish;
   logic             res_load;
   logic             out_free;
   logic [2:0]       res_status;
   logic [CNT_W-1:0] res_index;
   logic [31:0]      res_offset;
   logic             res_is_read;
   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   logic [3:0]       rsp_index_ff;
   logic [31:0]      rsp_offset_ff;
   logic             rsp_is_read_ff;

   logic q_rd, q_wr, q_fetch, handler_ok;

   assign q_rd    = qual_ff[mrtl_pkg::Q_READ_BIT];
   assign q_wr    = qual_ff[mrtl_pkg::Q_WRITE_BIT];
   assign q_fetch = qual_ff[mrtl_pkg::Q_FETCH_BIT];

   // read access needs a read handler, anything else a write handler
   assign handler_ok = q_rd ? rd_data_ff.rd_ok : rd_data_ff.wr_ok;

   assign idx_inc   = idx_ff + CNT_W'(1);
   assign idx_dec   = idx_ff - CNT_W'(1);
   assign idx_dec2  = idx_ff - CNT_W'(2);
   assign count_dec = count_ff - CNT_W'(1);

   assign req_ready = (state_ff == S_IDLE);
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   // shared compare unit: key against the entry under scan
   mrtl_cmp u_cmp (
      .key    (key_ff),
      .lo     (rd_data_ff.start_addr),
      .hi     (rd_data_ff.end_addr),
      .result (cmp)
   );

   // sequencer
   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      pos_in      = pos_ff;
      count_in    = count_ff;
      rd_addr     = idx_ff[IDX_W-1:0];
      mem_we      = 1'b0;
      mem_waddr   = idx_ff[IDX_W-1:0];
      mem_wdata   = rd_data_ff;
      finish      = 1'b0;
      res_status  = mrtl_pkg::ST_MISS;
      res_index   = '0;
      res_offset  = '0;
      res_is_read = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_START;
            end
         end

         S_START: begin
            idx_in  = '0;
            rd_addr = '0;
            if (type_ff == mrtl_pkg::REQ_LOOKUP) begin
               if (q_rd && q_wr) begin
                  finish     = 1'b1;
                  res_status = mrtl_pkg::ST_WALK_FAULT;
               end else if (q_fetch) begin
                  finish     = 1'b1;
                  res_status = mrtl_pkg::ST_FETCH;
               end else if (count_ff == '0) begin
                  finish     = 1'b1;
                  res_status = mrtl_pkg::ST_MISS;
               end else begin
                  state_in = S_SCAN;
               end
            end else begin
               if (count_ff == CNT_W'(MAX_RANGES)) begin
                  finish     = 1'b1;
                  res_status = mrtl_pkg::ST_FULL;
               end else if (count_ff == '0) begin
                  pos_in   = '0;
                  state_in = S_PLACE;
               end else begin
                  state_in = S_FIND;
               end
            end
         end

         // walk entries in order until a start above the address, a cover or the last entry
         S_SCAN: begin
            if (cmp.below_start) begin
               finish     = 1'b1;
               res_status = mrtl_pkg::ST_MISS;
            end else if (cmp.within_end) begin
               finish    = 1'b1;
               res_index = idx_ff;
               if (handler_ok) begin
                  res_status  = mrtl_pkg::ST_HIT;
                  res_offset  = cmp.offset;
                  res_is_read = q_rd;
               end else begin
                  res_status = mrtl_pkg::ST_NO_HANDLER;
               end
            end else if (idx_inc == count_ff) begin
               finish     = 1'b1;
               res_status = mrtl_pkg::ST_MISS;
            end else begin
               idx_in  = idx_inc;
               rd_addr = idx_inc[IDX_W-1:0];
            end
         end

         // find the first entry whose start lies above the new start
         S_FIND: begin
            if (cmp.below_start) begin
               pos_in   = idx_ff;
               idx_in   = count_ff;
               rd_addr  = count_dec[IDX_W-1:0];
               state_in = S_SHIFT;
            end else if (idx_inc == count_ff) begin
               pos_in   = count_ff;
               state_in = S_PLACE;
            end else begin
               idx_in  = idx_inc;
               rd_addr = idx_inc[IDX_W-1:0];
            end
         end

         // move entries up one slot, top first
         S_SHIFT: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[IDX_W-1:0];
            mem_wdata = rd_data_ff;
            if (idx_dec == pos_ff) begin
               state_in = S_PLACE;
            end else begin
               idx_in  = idx_dec;
               rd_addr = idx_dec2[IDX_W-1:0];
            end
         end

         // write the new range and report its slot
         S_PLACE: begin
            finish               = 1'b1;
            res_status           = mrtl_pkg::ST_INSERTED;
            res_index            = pos_ff;
            mem_we               = out_free;
            mem_waddr            = pos_ff[IDX_W-1:0];
            mem_wdata.start_addr = key_ff;
            mem_wdata.end_addr   = end_ff;
            mem_wdata.rd_ok      = rflag_ff;
            mem_wdata.wr_ok      = wflag_ff;
            if (out_free) begin
               count_in = count_ff + CNT_W'(1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase

      // hold the state until the output register can take the result
      if (finish) begin
         state_in = out_free ? S_IDLE : state_ff;
      end
   end

   assign res_load = finish & out_free;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (res_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // sequencer indexes
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      pos_ff <= pos_in;
   end

   // capture the accepted word
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         type_ff  <= req_type;
         key_ff   <= (req_type == mrtl_pkg::REQ_LOOKUP) ? req_access_addr : req_range_start;
         end_ff   <= req_range_end;
         rflag_ff <= req_read_allowed;
         wflag_ff <= req_write_allowed;
         qual_ff  <= req_qualification;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_ff[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= table_ff[rd_addr];
   end

   // result payload
   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_status_ff  <= res_status;
         rsp_index_ff   <= 4'(res_index);
         rsp_offset_ff  <= res_offset;
         rsp_is_read_ff <= res_is_read;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_entry_index  = rsp_index_ff;
   assign rsp_range_offset = rsp_offset_ff;
   assign rsp_is_read      = rsp_is_read_ff;

   `MRTL_ASSERT_NOW(a_load_when_free, res_load, (!rsp_valid_ff || rsp_ready),
      "result overwrote a pending word")
   `MRTL_ASSERT_NEXT(a_accept_starts, (req_valid && req_ready), (state_ff == S_START),
      "accepted word did not start the sequencer")
   `MRTL_ASSERT_NOW(a_scan_in_range, (state_ff == S_SCAN || state_ff == S_FIND),
      (idx_ff < count_ff), "scan index past fill count")
   `MRTL_ASSERT_NEXT(a_insert_grows, (res_load && res_status == mrtl_pkg::ST_INSERTED),
      (count_ff == $past(count_ff) + CNT_W'(1)), "insert did not grow the table")

endmodule
